// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the stable priority queue with rekey.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int PRIO_BITS_DEF = 16;
  localparam int KEY_W         = 64;
  localparam int IN_PRIO_W     = 16;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 88;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REKEY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/stable_priority_queue_with_rekey.sv -----
// Top level: sequencer, occupancy count and result register around a chain of entry cells.
// Sequencer: one shift pass to the cell chain per cycle. An accepted insert, pop, clear or
//   peek goes from S_IDLE to S_REPLY; a rekey that finds its key does its remove pass in
//   S_IDLE and its insert pass in S_REINS. S_REPLY loads the result register when the output
//   is free. in_tready is high only in S_IDLE, so a new transaction waits for the result.
// Reset: rst_n synchronous active low clears the count, sequencer and output valid;
//   entry storage is not reset.
`timescale 1ns / 1ps
module stable_priority_queue_with_rekey #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] mode, [66:3] entry_key, [82:67] entry_priority, [87:83] zero
  input  logic [spq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [2] head_valid, [66:3] head_key, [82:67] head_priority,
  // [87:83] entry_count
  output logic [spq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam longint PMAX = (64'sd1 <<< (PRIO_BITS - 1)) - 64'sd1;
  localparam longint PMIN = -(64'sd1 <<< (PRIO_BITS - 1));

  typedef enum logic [1:0] {
    S_IDLE,
    S_REINS,
    S_REPLY
  } state_t;

  state_t                               state_r, state_nxt;
  logic [CNT_W-1:0]                     count_r, count_nxt;
  logic [spq_pkg::STATUS_W-1:0]         status_r, status_nxt;
  logic [spq_pkg::KEY_W-1:0]            pend_key_r, pend_key_nxt;
  logic signed [PRIO_BITS-1:0]          pend_prio_r, pend_prio_nxt;
  logic                                 out_tvalid_r, out_tvalid_nxt;
  logic [spq_pkg::OUT_TDATA_W-1:0]      out_tdata_r, out_tdata_nxt;

  logic [spq_pkg::MODE_W-1:0]           in_mode;
  logic [spq_pkg::KEY_W-1:0]            in_key;
  logic signed [spq_pkg::IN_PRIO_W-1:0] in_prio;
  logic signed [63:0]                   prio_ext;
  logic signed [PRIO_BITS-1:0]          prio_sat;
  logic                                 accept;

  spq_pkg::cell_ctrl_t                  ctrl;
  logic signed [PRIO_BITS-1:0]          cmd_prio;
  logic                                 seen_head;

  logic [spq_pkg::KEY_W-1:0]            cell_key  [CAPACITY];
  logic signed [PRIO_BITS-1:0]          cell_prio [CAPACITY];
  logic                                 cell_le   [CAPACITY];
  logic                                 cell_seen [CAPACITY];

  logic                                 head_valid;
  logic [spq_pkg::KEY_W-1:0]            head_key;
  logic signed [spq_pkg::IN_PRIO_W-1:0] head_prio;

  assign in_mode = in_tdata[2:0];
  assign in_key  = in_tdata[66:3];
  assign in_prio = in_tdata[82:67];

  assign prio_ext = 64'(in_prio);
  always_comb begin
    if (prio_ext > PMAX) begin
      prio_sat = PRIO_BITS'(PMAX);
    end else if (prio_ext < PMIN) begin
      prio_sat = PRIO_BITS'(PMIN);
    end else begin
      prio_sat = PRIO_BITS'(prio_ext);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [spq_pkg::KEY_W-1:0]   l_key,  r_key;
    logic signed [PRIO_BITS-1:0] l_prio, r_prio;
    logic                        l_le,   s_in;

    if (i == 0) begin : g_first
      assign l_key  = '0;
      assign l_prio = '0;
      assign l_le   = 1'b1;
      assign s_in   = seen_head;
    end else begin : g_mid
      assign l_key  = cell_key[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_le   = cell_le[i-1];
      assign s_in   = cell_seen[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key  = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_key  = cell_key[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .CAPACITY  (CAPACITY),
      .PRIO_BITS (PRIO_BITS),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_prio   (cmd_prio),
      .count      (count_r),
      .left_key   (l_key),
      .left_prio  (l_prio),
      .left_le    (l_le),
      .right_key  (r_key),
      .right_prio (r_prio),
      .seen_in    (s_in),
      .key_q      (cell_key[i]),
      .prio_q     (cell_prio[i]),
      .le_out     (cell_le[i]),
      .seen_out   (cell_seen[i])
    );
  end

  assign head_valid = (count_r != '0);
  assign head_key   = head_valid ? cell_key[0] : '0;
  assign head_prio  = head_valid ? spq_pkg::IN_PRIO_W'(cell_prio[0]) : '0;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    pend_key_nxt   = pend_key_r;
    pend_prio_nxt  = pend_prio_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ctrl.op        = spq_pkg::CELL_HOLD;
    ctrl.key       = in_key;
    cmd_prio       = prio_sat;
    seen_head      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pend_key_nxt  = in_key;
          pend_prio_nxt = prio_sat;
          status_nxt    = spq_pkg::ST_OK;
          state_nxt     = S_REPLY;
          case (in_mode)
            spq_pkg::MODE_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = spq_pkg::ST_FULL;
              end else begin
                ctrl.op   = spq_pkg::CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            spq_pkg::MODE_REKEY: begin
              if (cell_seen[CAPACITY-1]) begin
                ctrl.op   = spq_pkg::CELL_REMOVE;
                count_nxt = count_r - 1'b1;
                state_nxt = S_REINS;
              end else begin
                status_nxt = spq_pkg::ST_NOT_FOUND;
              end
            end
            spq_pkg::MODE_POP: begin
              if (count_r == '0) begin
                status_nxt = spq_pkg::ST_EMPTY;
              end else begin
                seen_head = 1'b1;
                ctrl.op   = spq_pkg::CELL_REMOVE;
                count_nxt = count_r - 1'b1;
              end
            end
            spq_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = spq_pkg::ST_EMPTY;
              end
            end
          endcase
        end
      end
      S_REINS: begin
        ctrl.op   = spq_pkg::CELL_INSERT;
        ctrl.key  = pend_key_r;
        cmd_prio  = pend_prio_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {spq_pkg::COUNT_OUT_W'(count_r), head_prio, head_key,
                            head_valid, status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    status_r    <= status_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_prio_r <= pend_prio_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts left or right with its neighbours.
`timescale 1ns / 1ps
module spq_cell #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int IDX       = 0,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  spq_pkg::cell_ctrl_t         ctrl,
  input  logic signed [PRIO_BITS-1:0] new_prio,
  input  logic [CNT_W-1:0]            count,
  input  logic [spq_pkg::KEY_W-1:0]   left_key,
  input  logic signed [PRIO_BITS-1:0] left_prio,
  input  logic                        left_le,
  input  logic [spq_pkg::KEY_W-1:0]   right_key,
  input  logic signed [PRIO_BITS-1:0] right_prio,
  input  logic                        seen_in,
  output logic [spq_pkg::KEY_W-1:0]   key_q,
  output logic signed [PRIO_BITS-1:0] prio_q,
  output logic                        le_out,
  output logic                        seen_out
);

  logic [spq_pkg::KEY_W-1:0]   key_r,  key_nxt;
  logic signed [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                        occupied;

  assign occupied = (count > CNT_W'(IDX));
  // entry sits at or ahead of the new priority (stable: equal stays ahead)
  assign le_out   = occupied && (prio_r <= new_prio);
  // first matching key at or before this slot
  assign seen_out = seen_in | (occupied && (key_r == ctrl.key));

  always_comb begin
    key_nxt  = key_r;
    prio_nxt = prio_r;
    case (ctrl.op)
      spq_pkg::CELL_INSERT: begin
        if (!left_le) begin
          key_nxt  = left_key;
          prio_nxt = left_prio;
        end else if (!le_out) begin
          key_nxt  = ctrl.key;
          prio_nxt = new_prio;
        end
      end
      spq_pkg::CELL_REMOVE: begin
        if (seen_out) begin
          key_nxt  = right_key;
          prio_nxt = right_prio;
        end
      end
      default: begin
        key_nxt  = key_r;
        prio_nxt = prio_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prio_r <= prio_nxt;
  end

  assign key_q  = key_r;
  assign prio_q = prio_r;

endmodule
